### src/lpcf_pkg.sv
// Shared types, widths and constants for the line position centroid filter.
// No dependencies; used by the top level, the divider and the bench.
`default_nettype none

package lpcf_pkg;

   localparam int RAW_W      = 8;   // sensor channels
   localparam int CNT_W      = 4;   // 0..8 seen channels
   localparam int SUM_W      = 6;   // weighted sum, -16..16
   localparam int ERR_W      = 16;  // Q2.14 error words
   localparam int GAIN_W     = 16;  // Q0.16 filter gain
   localparam int FAIL_W     = 16;  // saturating failure counter
   localparam int FRAC_W     = 14;  // fraction bits of Q2.14
   localparam int QUO_W      = 15;  // quotient magnitude, at most 16384
   localparam int DEN_W      = 6;   // 7 * count, at most 49
   localparam int DVD_W      = SUM_W - 1 + FRAC_W;  // |sum| << 14
   localparam int DIV_CNT_W  = $clog2(QUO_W);
   localparam int PROD_W     = 2 * (ERR_W + 1);     // gain * difference
   localparam int NF_W       = PROD_W - GAIN_W;     // filtered + step

   localparam int RSP_DATA_W = 64;
   localparam int RSP_USER_W = 4;

   // csr register indexes
   localparam logic CSR_ACTIVE_HIGH = 1'b0;
   localparam logic CSR_FILTER_GAIN = 1'b1;

   localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd22938;

   // channel weights, channel 0 first
   localparam logic signed [SUM_W-1:0] CHAN_WEIGHT [RAW_W] = '{
      -6'sd7, -6'sd5, -6'sd3, -6'sd1, 6'sd1, 6'sd3, 6'sd5, 6'sd7
   };

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_DIV  = 5'b00010,
      ST_MUL  = 5'b00100,
      ST_ADD  = 5'b01000,
      ST_OUT  = 5'b10000
   } state_type;

   function automatic logic [CNT_W-1:0] count_seen(input logic [RAW_W-1:0] bits);
      logic [CNT_W-1:0] n;
      n = '0;
      for (int i = 0; i < RAW_W; i++) begin
         n = n + CNT_W'(bits[i]);
      end
      return n;
   endfunction

   function automatic logic signed [SUM_W-1:0] weight_sum(input logic [RAW_W-1:0] bits);
      logic signed [SUM_W-1:0] s;
      s = '0;
      for (int i = 0; i < RAW_W; i++) begin
         if (bits[i]) begin
            s = s + CHAN_WEIGHT[i];
         end
      end
      return s;
   endfunction

endpackage

`default_nettype wire

### src/lpcf_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on lpcf_pkg for operand widths.
`default_nettype none

module lpcf_div (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [lpcf_pkg::DVD_W-1:0]    dividend,
   input  wire logic [lpcf_pkg::DEN_W-1:0]    divisor,
   output logic                               done,
   output logic [lpcf_pkg::QUO_W-1:0]         quotient
);

   localparam int HI_W = lpcf_pkg::DVD_W - lpcf_pkg::QUO_W;
   localparam logic [lpcf_pkg::DIV_CNT_W-1:0] LAST_STEP =
      lpcf_pkg::DIV_CNT_W'(lpcf_pkg::QUO_W - 1);

   logic [lpcf_pkg::DEN_W-1:0]     rem_ff;
   logic [lpcf_pkg::QUO_W-1:0]     work_ff;
   logic [lpcf_pkg::DEN_W-1:0]     den_ff;
   logic [lpcf_pkg::DIV_CNT_W-1:0] step_ff;
   logic                           busy_ff;
   logic                           done_ff;

   logic [lpcf_pkg::DEN_W:0] part;
   logic [lpcf_pkg::DEN_W:0] trial;
   logic                     fits;

   // shared subtractor: partial remainder against divisor
   assign part  = {rem_ff, work_ff[lpcf_pkg::QUO_W-1]};
   assign trial = part - {1'b0, den_ff};
   assign fits  = part >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= busy_ff && (step_ff == LAST_STEP);
         if (busy_ff) begin
            step_ff <= step_ff + 1'b1;
            if (step_ff == LAST_STEP) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   // top bits start the remainder; the quotient stays below 2^15,
   // so they are already below the divisor
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff  <= lpcf_pkg::DEN_W'(dividend[lpcf_pkg::DVD_W-1 -: HI_W]);
         work_ff <= dividend[lpcf_pkg::QUO_W-1:0];
         den_ff  <= divisor;
      end else if (busy_ff) begin
         rem_ff  <= fits ? trial[lpcf_pkg::DEN_W-1:0] : part[lpcf_pkg::DEN_W-1:0];
         work_ff <= {work_ff[lpcf_pkg::QUO_W-2:0], fits};
      end
   end

   assign done     = done_ff;
   assign quotient = work_ff;

endmodule

`default_nettype wire

### src/line_position_centroid_filter_unit.sv
// Line position centroid filter: polarity, count, centroid divide, IIR filter.
// A valid position passes the 15-step shared divider, then a multiply and an add step, before
// it reaches the output state; lost, full or failed reads go straight to the output state.
// A new word is taken only in the idle state, after the last result word has been registered.
// Synchronous active-high reset clears the sequencer, held state, counter and csrs
// (active_high = 1, filter_gain = 22938); rsp_tvalid is low after reset.
`default_nettype none

module line_position_centroid_filter_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   // input words
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] raw_state
   input  wire logic        req_tuser,   // [0] read_ok
   // result words
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [7:0] seen_bits, [11:8] seen_count, [27:12] position_error,
   // [43:28] smoothed_error, [59:44] failure_count, [63:60] zero
   output logic [63:0]      rsp_tdata,
   // [0] read_good, [1] lost_flag, [2] full_flag, [3] position_valid
   output logic [3:0]       rsp_tuser,
   // csr writes
   input  wire logic        csr_we,
   input  wire logic        csr_addr,
   input  wire logic [15:0] csr_wdata
);

   lpcf_pkg::state_type state_ff, state_in;

   logic                              active_high_ff;
   logic [lpcf_pkg::GAIN_W-1:0]       gain_ff;

   logic [lpcf_pkg::RAW_W-1:0]        held_bits_ff;
   logic [lpcf_pkg::CNT_W-1:0]        held_count_ff;
   logic [lpcf_pkg::ERR_W-1:0]        last_error_ff;
   logic [lpcf_pkg::ERR_W-1:0]        filtered_ff;
   logic [lpcf_pkg::FAIL_W-1:0]       fail_ff;
   logic                              ok_ff;
   logic                              lost_ff;
   logic                              full_ff;
   logic                              pos_valid_ff;
   logic                              neg_ff;
   logic signed [lpcf_pkg::PROD_W-1:0] prod_ff;

   logic                              rsp_valid_ff;
   logic [lpcf_pkg::RSP_DATA_W-1:0]   rsp_data_ff;
   logic [lpcf_pkg::RSP_USER_W-1:0]   rsp_user_ff;

   logic                              accept;
   logic [lpcf_pkg::RAW_W-1:0]        bits;
   logic [lpcf_pkg::CNT_W-1:0]        count;
   logic signed [lpcf_pkg::SUM_W-1:0] sum;
   logic [lpcf_pkg::SUM_W-1:0]        sum_abs;
   logic                              lost;
   logic                              full;
   logic                              div_start;
   logic [lpcf_pkg::DVD_W-1:0]        dividend;
   logic [lpcf_pkg::DEN_W:0]          den_wide;
   logic                              div_done;
   logic [lpcf_pkg::QUO_W-1:0]        quotient;
   logic [lpcf_pkg::ERR_W-1:0]        err;
   logic signed [lpcf_pkg::ERR_W:0]   diff;
   logic signed [lpcf_pkg::NF_W-1:0]  nf;
   logic [lpcf_pkg::ERR_W-1:0]        nf_sat;
   logic                              out_free;

   assign req_tready = (state_ff == lpcf_pkg::ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // channel decode
   assign bits     = active_high_ff ? req_tdata : ~req_tdata;
   assign count    = lpcf_pkg::count_seen(bits);
   assign sum      = lpcf_pkg::weight_sum(bits);
   assign sum_abs  = sum[lpcf_pkg::SUM_W-1] ? -sum : sum;
   assign lost     = (count == '0);
   assign full     = (count == lpcf_pkg::CNT_W'(lpcf_pkg::RAW_W));
   assign div_start = accept && req_tuser && !lost && !full;
   assign dividend = {sum_abs[lpcf_pkg::SUM_W-2:0], {lpcf_pkg::FRAC_W{1'b0}}};
   assign den_wide = {count, 3'b000} - {3'b000, count};

   lpcf_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dividend),
      .divisor  (den_wide[lpcf_pkg::DEN_W-1:0]),
      .done     (div_done),
      .quotient (quotient)
   );

   // signed error and filter arithmetic
   assign err  = neg_ff ? -{1'b0, quotient} : {1'b0, quotient};
   assign diff = $signed({err[lpcf_pkg::ERR_W-1], err})
               - $signed({filtered_ff[lpcf_pkg::ERR_W-1], filtered_ff});
   // arithmetic shift by 16 rounds toward minus infinity
   assign nf   = $signed({{(lpcf_pkg::NF_W-lpcf_pkg::ERR_W){filtered_ff[lpcf_pkg::ERR_W-1]}},
                          filtered_ff})
               + prod_ff[lpcf_pkg::PROD_W-1:lpcf_pkg::GAIN_W];

   always_comb begin
      if (nf[lpcf_pkg::NF_W-1:lpcf_pkg::ERR_W-1] == '0 ||
          nf[lpcf_pkg::NF_W-1:lpcf_pkg::ERR_W-1] == '1) begin
         nf_sat = nf[lpcf_pkg::ERR_W-1:0];
      end else if (nf[lpcf_pkg::NF_W-1]) begin
         nf_sat = {1'b1, {(lpcf_pkg::ERR_W-1){1'b0}}};
      end else begin
         nf_sat = {1'b0, {(lpcf_pkg::ERR_W-1){1'b1}}};
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lpcf_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = div_start ? lpcf_pkg::ST_DIV : lpcf_pkg::ST_OUT;
            end
         end
         lpcf_pkg::ST_DIV: begin
            if (div_done) begin
               state_in = lpcf_pkg::ST_MUL;
            end
         end
         lpcf_pkg::ST_MUL: state_in = lpcf_pkg::ST_ADD;
         lpcf_pkg::ST_ADD: state_in = lpcf_pkg::ST_OUT;
         lpcf_pkg::ST_OUT: begin
            if (out_free) begin
               state_in = lpcf_pkg::ST_IDLE;
            end
         end
         default: state_in = lpcf_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= lpcf_pkg::ST_IDLE;
         active_high_ff <= 1'b1;
         gain_ff        <= lpcf_pkg::GAIN_RESET;
         held_bits_ff   <= '0;
         held_count_ff  <= '0;
         last_error_ff  <= '0;
         filtered_ff    <= '0;
         fail_ff        <= '0;
         ok_ff          <= 1'b0;
         lost_ff        <= 1'b0;
         full_ff        <= 1'b0;
         pos_valid_ff   <= 1'b0;
         neg_ff         <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;

         if (csr_we) begin
            unique case (csr_addr)
               lpcf_pkg::CSR_ACTIVE_HIGH: active_high_ff <= csr_wdata[0];
               lpcf_pkg::CSR_FILTER_GAIN: gain_ff        <= csr_wdata;
               default: ;
            endcase
         end

         if (accept) begin
            ok_ff <= req_tuser;
            if (req_tuser) begin
               held_bits_ff  <= bits;
               held_count_ff <= count;
               lost_ff       <= lost;
               full_ff       <= full;
               pos_valid_ff  <= !lost && !full;
               neg_ff        <= sum[lpcf_pkg::SUM_W-1];
            end else begin
               lost_ff      <= 1'b0;
               full_ff      <= 1'b0;
               pos_valid_ff <= 1'b0;
               if (fail_ff != '1) begin
                  fail_ff <= fail_ff + 1'b1;
               end
            end
         end

         if (state_ff == lpcf_pkg::ST_MUL) begin
            last_error_ff <= err;
         end
         if (state_ff == lpcf_pkg::ST_ADD) begin
            filtered_ff <= nf_sat;
         end

         // hold the result word until taken
         if (state_ff == lpcf_pkg::ST_OUT && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == lpcf_pkg::ST_MUL) begin
         prod_ff <= $signed({1'b0, gain_ff}) * diff;
      end
      if (state_ff == lpcf_pkg::ST_OUT && out_free) begin
         rsp_data_ff <= {4'b0000, fail_ff, filtered_ff, last_error_ff,
                         held_count_ff, held_bits_ff};
         rsp_user_ff <= {pos_valid_ff, full_ff, lost_ff, ok_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

`default_nettype wire

### src/lpcf_checker.sv
// Port-level checks for line_position_centroid_filter_unit, bound to the top level.
// Depends on the top level's port list only.
`default_nettype none

module lpcf_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [63:0] rsp_tdata,
   input wire logic [3:0]  rsp_tuser
);

   // no result word straight out of reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high after reset");

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result word changed");

   // one word in flight: ready drops after an accept
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second word accepted while busy");

   // position valid only on a good read that is neither lost nor full
   a_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tuser[3] && (!rsp_tuser[0] || rsp_tuser[1] || rsp_tuser[2])))
      else $error("position_valid with inconsistent flags");

   // lost means no channel counted, full means all eight
   a_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |->
         (rsp_tuser[1] == (rsp_tdata[11:8] == 4'd0)) &&
         (rsp_tuser[2] == (rsp_tdata[11:8] == 4'd8)))
      else $error("lost or full flag disagrees with seen_count");

endmodule

bind line_position_centroid_filter_unit lpcf_checker u_lpcf_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire

### bench/line_position_centroid_filter_unit_tb.sv
// Self-checking bench for line_position_centroid_filter_unit: directed table, random
// sensor readings over several csr settings, then a short mixed run.
// Depends on lpcf_pkg and the unit under test only.

module line_position_centroid_filter_unit_tb;

   localparam int SETTLE_CYCLES = 24;    // worst-case latency plus margin
   localparam int QUIET_LIMIT   = 2000;  // cycles without any handshake
   localparam int REPORT_MAX    = 200;
   localparam int PHASE_WORDS   = 150;

   typedef struct packed {
      logic                              read_good;
      logic [lpcf_pkg::RAW_W-1:0]        seen_bits;
      logic [lpcf_pkg::CNT_W-1:0]        seen_count;
      logic                              lost_flag;
      logic                              full_flag;
      logic                              position_valid;
      logic signed [lpcf_pkg::ERR_W-1:0] position_error;
      logic signed [lpcf_pkg::ERR_W-1:0] smoothed_error;
      logic [lpcf_pkg::FAIL_W-1:0]       failure_count;
   } line_result_type;

   typedef struct packed {
      logic                        active_high;
      logic [lpcf_pkg::GAIN_W-1:0] gain;
      logic [lpcf_pkg::RAW_W-1:0]  raw_state;
      logic                        read_ok;
      logic                        typed;
      line_result_type             want;
   } line_stim_type;

   localparam line_result_type NO_WANT = '0;

   // polarity, gain, raw, read_ok, typed, expected word
   localparam line_stim_type DIRECTED [22] = '{
      '{1'b1, lpcf_pkg::GAIN_RESET, 8'h00, 1'b1, 1'b1,
        '{1'b1, 8'h00, 4'd0, 1'b1, 1'b0, 1'b0, 16'sd0, 16'sd0, 16'd0}},
      '{1'b1, lpcf_pkg::GAIN_RESET, 8'hFF, 1'b1, 1'b1,
        '{1'b1, 8'hFF, 4'd8, 1'b0, 1'b1, 1'b0, 16'sd0, 16'sd0, 16'd0}},
      '{1'b1, lpcf_pkg::GAIN_RESET, 8'h5A, 1'b0, 1'b1,
        '{1'b0, 8'hFF, 4'd8, 1'b0, 1'b0, 1'b0, 16'sd0, 16'sd0, 16'd1}},
      '{1'b1, lpcf_pkg::GAIN_RESET, 8'h01, 1'b1, 1'b1,
        '{1'b1, 8'h01, 4'd1, 1'b0, 1'b0, 1'b1, -16'sd16384, -16'sd5735, 16'd1}},
      '{1'b1, lpcf_pkg::GAIN_RESET, 8'h80, 1'b1, 1'b0, NO_WANT},
      '{1'b1, lpcf_pkg::GAIN_RESET, 8'h03, 1'b1, 1'b0, NO_WANT},
      '{1'b1, lpcf_pkg::GAIN_RESET, 8'hC0, 1'b1, 1'b0, NO_WANT},
      '{1'b1, lpcf_pkg::GAIN_RESET, 8'h18, 1'b1, 1'b0, NO_WANT},
      '{1'b1, lpcf_pkg::GAIN_RESET, 8'h7F, 1'b1, 1'b0, NO_WANT},
      '{1'b1, lpcf_pkg::GAIN_RESET, 8'hFE, 1'b1, 1'b0, NO_WANT},
      '{1'b1, lpcf_pkg::GAIN_RESET, 8'h00, 1'b0, 1'b0, NO_WANT},
      '{1'b1, lpcf_pkg::GAIN_RESET, 8'hAA, 1'b1, 1'b0, NO_WANT},
      '{1'b1, lpcf_pkg::GAIN_RESET, 8'h55, 1'b1, 1'b0, NO_WANT},
      '{1'b0, lpcf_pkg::GAIN_RESET, 8'hFF, 1'b1, 1'b0, NO_WANT},
      '{1'b0, lpcf_pkg::GAIN_RESET, 8'h00, 1'b1, 1'b0, NO_WANT},
      '{1'b0, lpcf_pkg::GAIN_RESET, 8'hFE, 1'b1, 1'b0, NO_WANT},
      '{1'b0, lpcf_pkg::GAIN_RESET, 8'h7F, 1'b1, 1'b0, NO_WANT},
      '{1'b0, 16'd0,      8'h0F, 1'b1, 1'b0, NO_WANT},
      '{1'b0, 16'd0,      8'hF0, 1'b1, 1'b0, NO_WANT},
      '{1'b0, 16'hFFFF,   8'h01, 1'b1, 1'b0, NO_WANT},
      '{1'b0, 16'hFFFF,   8'h80, 1'b1, 1'b0, NO_WANT},
      '{1'b0, 16'hFFFF,   8'h80, 1'b0, 1'b0, NO_WANT}
   };

   logic              clock      = 1'b0;
   logic              reset      = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [7:0]        req_tdata  = '0;   // [7:0] raw_state
   logic              req_tuser  = 1'b0; // [0] read_ok
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   // [7:0] seen_bits, [11:8] seen_count, [27:12] position_error,
   // [43:28] smoothed_error, [59:44] failure_count
   logic [63:0]       rsp_tdata;
   // [0] read_good, [1] lost_flag, [2] full_flag, [3] position_valid
   logic [3:0]        rsp_tuser;
   logic              csr_we     = 1'b0;
   logic              csr_addr   = 1'b0;
   logic [15:0]       csr_wdata  = '0;

   // predictor state and csr copy
   logic                        cfg_active_high = 1'b1;
   logic [lpcf_pkg::GAIN_W-1:0] cfg_gain        = lpcf_pkg::GAIN_RESET;
   logic [lpcf_pkg::RAW_W-1:0]  seen_hold       = '0;
   int                          count_hold      = 0;
   int                          error_hold      = 0;
   int                          smooth_hold     = 0;
   logic [lpcf_pkg::FAIL_W-1:0] fail_total      = '0;

   line_result_type   pending_results [$];
   int                mismatches  = 0;
   int                quiet_cycles = 0;

   line_position_centroid_filter_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic line_result_type centroid_step(input logic [lpcf_pkg::RAW_W-1:0] raw,
                                                     input logic ok);
      line_result_type            r;
      logic [lpcf_pkg::RAW_W-1:0] bits;
      int                         ch;
      int                         weight_total;
      int                         n_seen;
      int                         err;
      longint                     nf;
      r = '0;
      if (ok) begin
         bits = cfg_active_high ? raw : ~raw;
         weight_total = 0;
         n_seen = 0;
         for (ch = 0; ch < lpcf_pkg::RAW_W; ch++) begin
            if (bits[ch]) begin
               weight_total += 2 * ch - 7;
               n_seen++;
            end
         end
         seen_hold = bits;
         count_hold = n_seen;
         r.lost_flag = (n_seen == 0);
         r.full_flag = (n_seen == lpcf_pkg::RAW_W);
         r.position_valid = !r.lost_flag && !r.full_flag;
         if (r.position_valid) begin
            // int division truncates toward zero; >>> floors the filter step
            err = (weight_total * (1 << lpcf_pkg::FRAC_W)) / (7 * n_seen);
            error_hold = err;
            nf = longint'(smooth_hold) +
                 ((longint'(cfg_gain) * longint'(err - smooth_hold)) >>> lpcf_pkg::GAIN_W);
            if (nf > 32767) nf = 32767;
            if (nf < -32768) nf = -32768;
            smooth_hold = int'(nf);
         end
      end else if (fail_total != '1) begin
         fail_total++;
      end
      r.read_good      = ok;
      r.seen_bits      = seen_hold;
      r.seen_count     = count_hold[lpcf_pkg::CNT_W-1:0];
      r.position_error = error_hold[lpcf_pkg::ERR_W-1:0];
      r.smoothed_error = smooth_hold[lpcf_pkg::ERR_W-1:0];
      r.failure_count  = fail_total;
      return r;
   endfunction

   task automatic check_field(input string name, input longint want, input longint got);
      if (want != got) begin
         if (mismatches < REPORT_MAX) begin
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
         end
         mismatches++;
      end
   endtask

   // Present one reading at a falling edge and record its expected word on accept.
   task automatic send_reading(input logic [lpcf_pkg::RAW_W-1:0] raw, input logic ok,
                               input logic typed, input line_result_type want);
      int              gap;
      line_result_type pred;
      gap = $urandom_range(0, 14);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tdata  <= raw;
      req_tuser  <= ok;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!(req_tvalid && req_tready)) @(posedge clock);
      pred = centroid_step(raw, ok);
      pending_results.push_back(typed ? want : pred);
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (pending_results.size() != 0);
   endtask

   task automatic settle();
      drain_results();
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input logic addr, input logic [15:0] value);
      csr_addr  <= addr;
      csr_wdata <= value;
      csr_we    <= 1'b1;
      @(negedge clock);
      csr_we <= 1'b0;
      if (addr == lpcf_pkg::CSR_ACTIVE_HIGH) cfg_active_high = value[0];
      else cfg_gain = value;
      @(negedge clock);
   endtask

   initial begin : stimulus
      int                          phase;
      int                          k;
      logic [lpcf_pkg::RAW_W-1:0]  raw;
      logic [lpcf_pkg::GAIN_W-1:0] gain;
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (k = 0; k < $size(DIRECTED); k++) begin
         if (DIRECTED[k].active_high != cfg_active_high) begin
            settle();
            write_csr(lpcf_pkg::CSR_ACTIVE_HIGH, 16'(DIRECTED[k].active_high));
         end
         if (DIRECTED[k].gain != cfg_gain) begin
            settle();
            write_csr(lpcf_pkg::CSR_FILTER_GAIN, DIRECTED[k].gain);
         end
         send_reading(DIRECTED[k].raw_state, DIRECTED[k].read_ok,
                      DIRECTED[k].typed, DIRECTED[k].want);
      end

      for (phase = 0; phase < 6; phase++) begin
         case (phase)
            0:       gain = 16'hFFFF;
            1:       gain = 16'd0;
            2:       gain = 16'd1;
            default: gain = 16'($urandom_range(0, 65535));
         endcase
         settle();
         write_csr(lpcf_pkg::CSR_ACTIVE_HIGH, 16'(phase % 2));
         write_csr(lpcf_pkg::CSR_FILTER_GAIN, gain);
         for (k = 0; k < PHASE_WORDS; k++) begin
            // hold off once per phase until the pipe is empty
            if (k == PHASE_WORDS / 2) drain_results();
            case ($urandom_range(0, 7))
               0:       raw = 8'h00;
               1:       raw = 8'hFF;
               2:       raw = 8'h01 << $urandom_range(0, 7);
               default: raw = 8'($urandom_range(0, 255));
            endcase
            send_reading(raw, ($urandom_range(0, 9) != 0), 1'b0, NO_WANT);
         end
      end

      settle();
      repeat (30) begin
         send_reading(8'($urandom_range(0, 255)), ($urandom_range(0, 2) != 0),
                      1'b0, NO_WANT);
      end

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin : result_sink
      int              stall;
      line_result_type got;
      line_result_type want;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         stall = $urandom_range(0, 14);
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!(rsp_tvalid && rsp_tready)) @(posedge clock);
         got.read_good      = rsp_tuser[0];
         got.lost_flag      = rsp_tuser[1];
         got.full_flag      = rsp_tuser[2];
         got.position_valid = rsp_tuser[3];
         got.seen_bits      = rsp_tdata[7:0];
         got.seen_count     = rsp_tdata[11:8];
         got.position_error = rsp_tdata[27:12];
         got.smoothed_error = rsp_tdata[43:28];
         got.failure_count  = rsp_tdata[59:44];
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected word, expected none got tdata=%h tuser=%h",
                     $time, rsp_tdata, rsp_tuser);
            mismatches++;
         end else begin
            want = pending_results.pop_front();
            check_field("read_good", want.read_good, got.read_good);
            check_field("seen_bits", want.seen_bits, got.seen_bits);
            check_field("seen_count", want.seen_count, got.seen_count);
            check_field("lost_flag", want.lost_flag, got.lost_flag);
            check_field("full_flag", want.full_flag, got.full_flag);
            check_field("position_valid", want.position_valid, got.position_valid);
            check_field("position_error", want.position_error, got.position_error);
            check_field("smoothed_error", want.smoothed_error, got.smoothed_error);
            check_field("failure_count", want.failure_count, got.failure_count);
         end
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles == QUIET_LIMIT) begin
         $display("%0t: no handshake for %0d cycles, %0d words outstanding",
                  $time, QUIET_LIMIT, pending_results.size());
         $display("CHECKS FAILED");
         $finish;
      end
   end

endmodule
